// ----- rtl/orpr_pkg.sv -----
// ----------------------------------------------------------------------------
// orpr_pkg
// Shared types, codes and helpers of the owned range pin registry.
// ----------------------------------------------------------------------------
package orpr_pkg;

   // table geometry
   localparam int NUM_RANGES = 64;
   localparam int PIN_BITS   = 16;
   localparam int IDX_W      = $clog2(NUM_RANGES);
   localparam int CNT_W      = $clog2(NUM_RANGES + 1);
   localparam int COUNT_W    = 7;

   // request codes
   localparam logic [3:0] OP_REGISTER      = 4'd0;
   localparam logic [3:0] OP_COMMIT        = 4'd1;
   localparam logic [3:0] OP_UNREGISTER    = 4'd2;
   localparam logic [3:0] OP_PIN           = 4'd3;
   localparam logic [3:0] OP_RELEASE_PIN   = 4'd4;
   localparam logic [3:0] OP_CHECK         = 4'd5;
   localparam logic [3:0] OP_FIND_BASE     = 4'd6;
   localparam logic [3:0] OP_REVOKE        = 4'd7;
   localparam logic [3:0] OP_RELEASE_OWNER = 4'd8;
   localparam logic [3:0] OP_RESET_LIFE    = 4'd9;
   localparam logic [3:0] OP_SHUTDOWN      = 4'd10;
   localparam logic [3:0] OP_BEGIN_OWNER   = 4'd11;
   localparam logic [3:0] OP_LIVE_COUNT    = 4'd12;
   localparam logic [3:0] OP_OWNER_COUNT   = 4'd13;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_ZERO_LEN  = 3'd1;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
   localparam logic [2:0] ERR_OVERLAP   = 3'd3;
   localparam logic [2:0] ERR_NO_RANGE  = 3'd4;
   localparam logic [2:0] ERR_TORN_DOWN = 3'd5;
   localparam logic [2:0] ERR_NO_AUTH   = 3'd6;
   localparam logic [2:0] ERR_FULL      = 3'd7;

   // life states
   localparam logic [1:0] LS_PROV     = 2'd0;
   localparam logic [1:0] LS_LIVE     = 2'd1;
   localparam logic [1:0] LS_RETIRE   = 2'd2;
   localparam logic [1:0] LS_RELEASED = 2'd3;

   // access codes
   localparam logic [1:0] ACC_READ  = 2'd0;
   localparam logic [1:0] ACC_WRITE = 2'd1;
   localparam logic [1:0] ACC_EXEC  = 2'd2;

   // policy codes
   localparam logic [2:0] POL_ANY      = 3'd0;
   localparam logic [2:0] POL_WRITABLE = 3'd1;
   localparam logic [2:0] POL_HEAP     = 3'd2;
   localparam logic [2:0] POL_MAPPED   = 3'd3;
   localparam logic [2:0] POL_CALLBACK = 3'd4;

   // kinds
   localparam logic [2:0] KIND_CPU      = 3'd0;
   localparam logic [2:0] KIND_GPU      = 3'd1;
   localparam logic [2:0] KIND_TEXT     = 3'd2;
   localparam logic [2:0] KIND_CALLABLE = 3'd3;

   // permission flag bits
   localparam int PF_READ     = 0;
   localparam int PF_WRITE    = 1;
   localparam int PF_EXEC     = 2;
   localparam int PF_INTERIOR = 3;
   localparam int PF_HEAP     = 4;

   localparam logic [33:0] SPACE_END = 34'h1_0000_0000;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [7:0]  owner;
      logic [31:0] address;
      logic [32:0] length_bytes;
      logic [31:0] range_id;
      logic [1:0]  access;
      logic [2:0]  policy;
      logic [2:0]  kind;
      logic [4:0]  perm_flags;
      logic [31:0] lifetime_tag;
   } req_item_type;

   typedef struct packed {
      logic        ok;
      logic [2:0]  error_code;
      logic [31:0] result_id;
      logic [31:0] result_base;
      logic [32:0] result_length;
      logic [2:0]  result_kind;
      logic [6:0]  count;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0]         base;
      logic [32:0]         length;
      logic [7:0]          owner;
      logic [2:0]          kind;
      logic [4:0]          perms;
      logic [1:0]          life;
      logic [PIN_BITS-1:0] pins;
      logic [31:0]         lifetime;
      logic [31:0]         ident;
   } entry_type;

   // per-entry predicates of the scan
   typedef struct packed {
      logic free;
      logic own;
      logic live;
      logic own_cnt;
      logic id_hit;
      logic overlap;
      logic cand;
      logic base_hit;
   } match_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } fsm_state_type;

   // exclusive end of a span, one bit wider than the length so the sum cannot overflow
   function automatic logic [33:0] span_end(logic [31:0] addr, logic [32:0] len);
      return {2'b00, addr} + {1'b0, len};
   endfunction

endpackage

// ----- rtl/orpr_ram.sv -----
// ----------------------------------------------------------------------------
// orpr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module orpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/orpr_match.sv -----
// ----------------------------------------------------------------------------
// orpr_match
// Evaluates one table entry against the held request during the scan.
// ----------------------------------------------------------------------------
module orpr_match (
   input  orpr_pkg::entry_type    entry,
   input  logic                   entry_valid,
   input  orpr_pkg::req_item_type req,
   output orpr_pkg::match_type    match
);
   import orpr_pkg::*;

   logic [33:0] q_end;
   logic [33:0] r_end;
   logic        contain;
   logic        interior_ok;
   logic        access_ok;
   logic        policy_ok;
   logic        own;

   assign q_end = span_end(req.address, req.length_bytes);
   assign r_end = span_end(entry.base, entry.length);
   assign own   = entry_valid && (entry.owner == req.owner);

   // queried span lies inside the entry
   assign contain = (entry.base <= req.address) && ({2'b00, req.address} < r_end) &&
                    (r_end >= q_end);

   assign interior_ok = entry.perms[PF_INTERIOR] || (req.address == entry.base);

   // access gate
   always_comb begin
      unique case (req.access)
         ACC_READ:  access_ok = entry.perms[PF_READ];
         ACC_WRITE: access_ok = entry.perms[PF_WRITE];
         ACC_EXEC:  access_ok = entry.perms[PF_EXEC];
         default:   access_ok = 1'b0;
      endcase
   end

   // policy gate
   always_comb begin
      unique case (req.policy)
         POL_ANY:      policy_ok = entry.perms[PF_READ];
         POL_WRITABLE: policy_ok = entry.perms[PF_WRITE];
         POL_HEAP:     policy_ok = entry.perms[PF_HEAP];
         POL_MAPPED:   policy_ok = (entry.kind == KIND_CPU) || (entry.kind == KIND_GPU);
         POL_CALLBACK: policy_ok = entry.perms[PF_EXEC] &&
                                   ((entry.kind == KIND_TEXT) || (entry.kind == KIND_CALLABLE));
         default:      policy_ok = 1'b0;
      endcase
   end

   assign match.free     = !entry_valid;
   assign match.own      = own;
   assign match.live     = entry_valid && (entry.life == LS_LIVE);
   assign match.own_cnt  = own && (entry.life != LS_RELEASED);
   assign match.id_hit   = entry_valid && (entry.ident == req.range_id);
   assign match.overlap  = entry_valid && (entry.owner != req.owner) &&
                           ({2'b00, entry.base} < q_end) && ({2'b00, req.address} < r_end);
   assign match.cand     = own && (entry.life == LS_LIVE) && contain && interior_ok &&
                           access_ok && policy_ok;
   assign match.base_hit = own && (entry.life == LS_LIVE) && (entry.base == req.address);

endmodule

// ----- rtl/owned_range_pin_registry.sv -----
// ----------------------------------------------------------------------------
// owned_range_pin_registry
// Table of owned guest memory ranges with pin counts, kept in one RAM.
// ----------------------------------------------------------------------------
// flow: the idle state takes a request, the scan reads one entry a cycle over the
//   registered RAM read port, and the finishing step writes back the chosen entry and
//   registers the result, waiting while a previous result is still held; a new
//   request is taken only in the idle state
// reset: synchronous; clears all valid bits, next id to one, current lifetime to 0
// the result register lets a new request scan while the previous result waits
module owned_range_pin_registry (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  orpr_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output orpr_pkg::rsp_item_type rsp_item
);
   import orpr_pkg::*;

   localparam int EW = $bits(entry_type);

   fsm_state_type       state_ff, state_in;
   req_item_type        req_ff;
   logic [IDX_W:0]      cnt_ff;
   logic [NUM_RANGES-1:0] valid_ff;
   logic [31:0]         next_ident_ff, next_ident_in;
   logic [31:0]         cur_life_ff, cur_life_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    found_idx_ff, found_idx_in;
   entry_type           found_ent_ff, found_ent_in;
   logic                free_found_ff, free_found_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                overlap_ff, overlap_in;
   logic [CNT_W-1:0]    acc_ff, acc_in;
   rsp_item_type        rsp_ff, rsp_in;
   logic                rsp_valid_ff;

   logic                accept;
   logic                scan_done;
   logic                fin_go;
   logic                ev_act;
   logic                ev_valid;
   logic [IDX_W-1:0]    eidx;
   logic [EW-1:0]       rd_data;
   entry_type           ent;
   match_type           mt;
   logic                sel;
   logic                better;
   logic                scan_we, scan_clr;
   entry_type           scan_wdata;
   logic                fin_we, fin_set, fin_clr;
   logic [IDX_W-1:0]    fin_idx;
   entry_type           fin_wdata;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   entry_type           ram_wdata;
   logic [33:0]         q_end;
   logic                len_zero, len_ovf;
   logic [PIN_BITS-1:0] pins_dec;

   // entry store
   orpr_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_RANGES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign ent      = entry_type'(rd_data);
   assign eidx     = IDX_W'(cnt_ff - 1'b1);
   assign ev_act   = (state_ff == ST_SCAN) && (cnt_ff != '0);
   assign ev_valid = valid_ff[eidx];

   orpr_match u_match (
      .entry       (ent),
      .entry_valid (ev_valid),
      .req         (req_ff),
      .match       (mt)
   );

   assign accept    = req_valid && req_ready;
   assign scan_done = (cnt_ff == (IDX_W+1)'(NUM_RANGES));
   assign fin_go    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and handshake
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (fin_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // per-entry scan step
   always_comb begin
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_ent_in  = found_ent_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      overlap_in    = overlap_ff;
      acc_in        = acc_ff;
      scan_we       = 1'b0;
      scan_clr      = 1'b0;
      scan_wdata    = ent;
      sel           = 1'b0;
      better        = !found_ff;
      if (ev_act) begin
         unique case (req_ff.req_type)
            OP_REGISTER: begin
               if (mt.free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = eidx;
               end
               if (mt.overlap) overlap_in = 1'b1;
            end
            OP_COMMIT, OP_UNREGISTER, OP_RELEASE_PIN: begin
               sel = mt.id_hit;
            end
            OP_PIN, OP_CHECK: begin
               sel    = mt.cand;
               better = !found_ff || (ent.length < found_ent_ff.length) ||
                        ((ent.length == found_ent_ff.length) &&
                         ((ent.base < found_ent_ff.base) ||
                          ((ent.base == found_ent_ff.base) &&
                           (ent.ident < found_ent_ff.ident))));
            end
            OP_FIND_BASE: begin
               sel    = mt.base_hit;
               better = !found_ff || (ent.ident < found_ent_ff.ident);
            end
            OP_REVOKE: begin
               if (mt.own && (ent.life == LS_LIVE)) begin
                  scan_we         = 1'b1;
                  scan_wdata.life = LS_RETIRE;
               end
            end
            OP_RELEASE_OWNER: begin
               if (mt.own) begin
                  if (ent.pins == '0) begin
                     scan_clr = 1'b1;
                  end else begin
                     scan_we         = 1'b1;
                     scan_wdata.life = LS_RETIRE;
                  end
               end
            end
            OP_RESET_LIFE: begin
               if (ev_valid && (ent.lifetime != req_ff.lifetime_tag) && (ent.pins == '0))
                  scan_clr = 1'b1;
            end
            OP_SHUTDOWN: begin
               if (ev_valid && (ent.pins == '0)) scan_clr = 1'b1;
            end
            OP_LIVE_COUNT: begin
               if (mt.live) acc_in = acc_ff + 1'b1;
            end
            OP_OWNER_COUNT: begin
               if (mt.own_cnt) acc_in = acc_ff + 1'b1;
            end
            default: ;
         endcase
         if (sel && better) begin
            found_in     = 1'b1;
            found_idx_in = eidx;
            found_ent_in = ent;
         end
      end
   end

   assign q_end    = span_end(req_ff.address, req_ff.length_bytes);
   assign len_zero = (req_ff.length_bytes == '0);
   assign len_ovf  = (q_end > SPACE_END);
   assign pins_dec = (found_ent_ff.pins != '0) ? found_ent_ff.pins - 1'b1 : '0;

   // finishing step: result and write back of the chosen entry
   always_comb begin
      rsp_in        = '0;
      fin_we        = 1'b0;
      fin_set       = 1'b0;
      fin_clr       = 1'b0;
      fin_idx       = found_idx_ff;
      fin_wdata     = found_ent_ff;
      next_ident_in = next_ident_ff;
      cur_life_in   = cur_life_ff;
      unique case (req_ff.req_type)
         OP_REGISTER: begin
            fin_idx                = free_idx_ff;
            fin_wdata.base         = req_ff.address;
            fin_wdata.length       = req_ff.length_bytes;
            fin_wdata.owner        = req_ff.owner;
            fin_wdata.kind         = req_ff.kind;
            fin_wdata.perms        = req_ff.perm_flags;
            fin_wdata.life         = LS_PROV;
            fin_wdata.pins         = '0;
            fin_wdata.lifetime     = (req_ff.lifetime_tag != '0) ? req_ff.lifetime_tag :
                                                                     cur_life_ff;
            fin_wdata.ident        = next_ident_ff;
            priority if (len_zero) begin
               rsp_in.error_code = ERR_ZERO_LEN;
            end else if (len_ovf) begin
               rsp_in.error_code = ERR_OVERFLOW;
            end else if (overlap_ff) begin
               rsp_in.error_code = ERR_OVERLAP;
            end else if (!free_found_ff) begin
               rsp_in.error_code = ERR_FULL;
            end else begin
               fin_we           = 1'b1;
               fin_set          = 1'b1;
               rsp_in.ok        = 1'b1;
               rsp_in.result_id = next_ident_ff;
               next_ident_in    = next_ident_ff + 1'b1;
            end
         end
         OP_COMMIT: begin
            fin_wdata.life = LS_LIVE;
            priority if (!found_ff) begin
               rsp_in.error_code = ERR_NO_RANGE;
            end else if (found_ent_ff.life >= LS_RETIRE) begin
               rsp_in.error_code = ERR_TORN_DOWN;
            end else begin
               fin_we    = 1'b1;
               rsp_in.ok = 1'b1;
            end
         end
         OP_UNREGISTER: begin
            fin_wdata.life = LS_RETIRE;
            if (!found_ff) begin
               rsp_in.error_code = ERR_NO_RANGE;
            end else begin
               rsp_in.ok = 1'b1;
               if (found_ent_ff.pins != '0) fin_we  = 1'b1;
               else                         fin_clr = 1'b1;
            end
         end
         OP_PIN, OP_CHECK: begin
            fin_wdata.pins = found_ent_ff.pins + 1'b1;
            priority if (len_zero) begin
               rsp_in.error_code = ERR_ZERO_LEN;
            end else if (len_ovf) begin
               rsp_in.error_code = ERR_OVERFLOW;
            end else if (!found_ff) begin
               rsp_in.error_code = ERR_NO_AUTH;
            end else begin
               rsp_in.ok            = 1'b1;
               rsp_in.result_id     = found_ent_ff.ident;
               rsp_in.result_base   = found_ent_ff.base;
               rsp_in.result_length = found_ent_ff.length;
               rsp_in.result_kind   = found_ent_ff.kind;
               // pin count saturates at all ones
               if ((req_ff.req_type == OP_PIN) && (found_ent_ff.pins != '1)) fin_we = 1'b1;
            end
         end
         OP_RELEASE_PIN: begin
            fin_wdata.pins = pins_dec;
            if (!found_ff) begin
               rsp_in.error_code = ERR_NO_RANGE;
            end else begin
               rsp_in.ok = 1'b1;
               // a retiring entry goes on its last unpin
               if ((pins_dec == '0) && (found_ent_ff.life == LS_RETIRE)) fin_clr = 1'b1;
               else                                                      fin_we  = 1'b1;
            end
         end
         OP_FIND_BASE: begin
            if (!found_ff) begin
               rsp_in.error_code = ERR_NO_RANGE;
            end else begin
               rsp_in.ok        = 1'b1;
               rsp_in.result_id = found_ent_ff.ident;
            end
         end
         OP_REVOKE, OP_RELEASE_OWNER, OP_SHUTDOWN: begin
            rsp_in.ok = 1'b1;
         end
         OP_RESET_LIFE: begin
            rsp_in.ok   = 1'b1;
            cur_life_in = req_ff.lifetime_tag;
         end
         OP_BEGIN_OWNER: begin
            rsp_in.ok = 1'b1;
            if (req_ff.lifetime_tag != '0) cur_life_in = req_ff.lifetime_tag;
         end
         OP_LIVE_COUNT, OP_OWNER_COUNT: begin
            rsp_in.ok    = 1'b1;
            rsp_in.count = COUNT_W'(acc_ff);
         end
         default: ;
      endcase
   end

   // one RAM write port shared by the scan and the finishing step
   always_comb begin
      if (state_ff == ST_FINISH) begin
         ram_we    = fin_go && fin_we;
         ram_waddr = fin_idx;
         ram_wdata = fin_wdata;
      end else begin
         ram_we    = scan_we;
         ram_waddr = eidx;
         ram_wdata = scan_wdata;
      end
   end

   // valid bits, id counter and lifetime
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         next_ident_ff <= 32'd1;
         cur_life_ff   <= '0;
      end else begin
         if (scan_clr) valid_ff[eidx] <= 1'b0;
         if (fin_go) begin
            if (fin_set) valid_ff[fin_idx] <= 1'b1;
            if (fin_clr) valid_ff[fin_idx] <= 1'b0;
            next_ident_ff <= next_ident_in;
            cur_life_ff   <= cur_life_in;
         end
      end
   end

   // scan control and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         overlap_ff    <= 1'b0;
         acc_ff        <= '0;
      end else if (accept) begin
         cnt_ff        <= '0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         overlap_ff    <= 1'b0;
         acc_ff        <= '0;
      end else if (state_ff == ST_SCAN) begin
         cnt_ff        <= cnt_ff + 1'b1;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         overlap_ff    <= overlap_in;
         acc_ff        <= acc_in;
      end
   end

   // request and chosen entry payload
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_item;
      if (state_ff == ST_SCAN) begin
         found_idx_ff <= found_idx_in;
         found_ent_ff <= found_ent_in;
         free_idx_ff  <= free_idx_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- rtl/orpr_checker.sv -----
// ----------------------------------------------------------------------------
// orpr_checker
// Port-level checks of the owned range pin registry, bound to the top level.
// ----------------------------------------------------------------------------
module orpr_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input orpr_pkg::rsp_item_type rsp_item
);
   import orpr_pkg::*;

   // a waiting result holds still
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // no result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an accepted item keeps the block busy for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken during a scan");

   // success carries no error code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.ok |-> rsp_item.error_code == ERR_NONE)
      else $error("ok result with an error code");

   // a failed request reports no id
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.ok |-> rsp_item.result_id == '0)
      else $error("failed result with an id");

endmodule

bind owned_range_pin_registry orpr_checker u_orpr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
